FILE: rtl/ilir_pkg.sv
// Shared types and codes for the indexed list block.
// Request and response beat structs, op and status codes, register map.
// No dependencies.
package ilir_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int ELEM_BITS_DEF = 32;

    localparam int OP_W    = 4;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int TAG_W   = 4;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 7;
    localparam int CAP_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
    localparam logic [TAG_W-1:0] ELEM_TYPE_RESET = 4'd0;

    // register index, taken from paddr[2] (word aligned)
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_ELEM_TYPE = 1'b1;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [OP_W-1:0] OP_PUSH_AT    = 4'd2;
    localparam logic [OP_W-1:0] OP_GET        = 4'd3;
    localparam logic [OP_W-1:0] OP_SET        = 4'd4;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd5;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd6;
    localparam logic [OP_W-1:0] OP_POP_AT     = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_TYPE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_BOUNDS = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
        logic [TAG_W-1:0] type_tag;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]  length;
    } rsp_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GET  = 6'b000010,
        S_INS  = 6'b000100,
        S_INSV = 6'b001000,
        S_REM  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

endpackage

FILE: rtl/indexed_list_insert_remove_top.sv
// Indexed list with insert/remove at any position, elements in one sync RAM; uses ilir_pkg.
// One request at a time; steps from accept to response load (L = length, i = index):
//   push_back, set, clear, errors, unknown ops, insert at i = L: direct; get: RAM read;
//   insert at i < L: shift up, write; remove: read, shift down. Next beat the cycle after.
// A stalled output holds one response; a second finished one parks and stalls the input.
// Reset: length 0, capacity 64, element_type 0; RAM contents left undefined.
module indexed_list_insert_remove_top #(
    parameter int DEPTH     = ilir_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = ilir_pkg::ELEM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ilir_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ilir_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ilir_pkg::PADDR_W-1:0]  paddr,
    input  logic [ilir_pkg::PDATA_W-1:0]  pwdata,
    output logic [ilir_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AX_W   = (ADDR_W > ilir_pkg::LEN_W) ? ADDR_W : ilir_pkg::LEN_W;
    localparam int EX_W   = (ELEM_BITS > ilir_pkg::VAL_W) ? ELEM_BITS : ilir_pkg::VAL_W;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ilir_pkg::LEN_W-1:0] x);
        logic [AX_W-1:0] w;
        w = AX_W'(x);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [ELEM_BITS-1:0] to_elem(input logic [ilir_pkg::VAL_W-1:0] v);
        logic [EX_W-1:0] w;
        w = EX_W'(v);
        return w[ELEM_BITS-1:0];
    endfunction

    function automatic logic [ilir_pkg::VAL_W-1:0] from_elem(input logic [ELEM_BITS-1:0] e);
        logic [EX_W-1:0] w;
        w = EX_W'(e);
        return w[ilir_pkg::VAL_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [ilir_pkg::CAP_W-1:0] capacity_reg;
    logic [ilir_pkg::TAG_W-1:0] element_type_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= ilir_pkg::CAPACITY_RESET;
            element_type_reg <= ilir_pkg::ELEM_TYPE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ilir_pkg::REG_CAPACITY:  capacity_reg <= pwdata[ilir_pkg::CAP_W-1:0];
                ilir_pkg::REG_ELEM_TYPE: element_type_reg <= pwdata[ilir_pkg::TAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ilir_pkg::REG_CAPACITY:  prdata = ilir_pkg::PDATA_W'(capacity_reg);
            ilir_pkg::REG_ELEM_TYPE: prdata = ilir_pkg::PDATA_W'(element_type_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- element RAM ----------------
    logic [ELEM_BITS-1:0] mem [DEPTH];
    logic [ELEM_BITS-1:0] mem_rd_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ELEM_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rd_reg <= mem[mem_raddr];
    end

    // ---------------- control ----------------
    ilir_pkg::state_t           state_reg, state_next;
    logic [ilir_pkg::LEN_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0]          cur_reg, cur_next;
    logic [ADDR_W-1:0]          stop_reg, stop_next;
    logic [ELEM_BITS-1:0]       val_reg, val_next;
    logic                       first_reg, first_next;
    ilir_pkg::rsp_t             res_reg, res_next;
    ilir_pkg::rsp_t             rsp_reg;
    logic                       rsp_valid_reg;

    logic [ilir_pkg::LEN_W-1:0] slots;
    logic                       tag_ok;
    logic                       full;
    logic                       out_free;
    logic                       out_load;
    ilir_pkg::rsp_t             out_data;

    // usable slots: capacity clamped to 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
            slots = ilir_pkg::LEN_W'(1);
        else if (int'(capacity_reg) > DEPTH)
            slots = ilir_pkg::LEN_W'(DEPTH);
        else
            slots = capacity_reg;
    end

    assign tag_ok    = (req.type_tag == element_type_reg);
    assign full      = (len_reg >= slots);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ilir_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [ilir_pkg::LEN_W-1:0] idx;
        logic                       done;
        ilir_pkg::rsp_t             done_res;

        state_next = state_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        stop_next  = stop_reg;
        val_next   = val_reg;
        first_next = first_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_reg;
        mem_wdata  = val_reg;
        mem_raddr  = cur_reg;
        out_load   = 1'b0;
        out_data   = res_reg;
        done       = 1'b0;
        done_res   = '0;
        idx        = '0;

        unique case (state_reg)
            ilir_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op) inside
                        ilir_pkg::OP_CLEAR:
                        begin
                            // live cells need no zeroing: they are only read after a push
                            len_next = '0;
                            done     = 1'b1;
                        end
                        ilir_pkg::OP_PUSH_BACK, ilir_pkg::OP_PUSH_FRONT,
                        ilir_pkg::OP_PUSH_AT:
                        begin
                            if (req.op == ilir_pkg::OP_PUSH_BACK)
                                idx = len_reg;
                            else if (req.op == ilir_pkg::OP_PUSH_FRONT)
                                idx = '0;
                            else
                                idx = req.position;

                            if (!tag_ok)
                            begin
                                done_res.status = ilir_pkg::ST_TYPE;
                                done            = 1'b1;
                            end
                            else if (req.op == ilir_pkg::OP_PUSH_AT && req.position > len_reg)
                            begin
                                done_res.status = ilir_pkg::ST_BOUNDS;
                                done            = 1'b1;
                            end
                            else if (full)
                            begin
                                done_res.status = ilir_pkg::ST_FULL;
                                done            = 1'b1;
                            end
                            else
                            begin
                                len_next = len_reg + 1'b1;
                                val_next = to_elem(req.value);
                                if (idx == len_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = to_addr(len_reg);
                                    mem_wdata = to_elem(req.value);
                                    done      = 1'b1;
                                end
                                else
                                begin
                                    // shift up, starting from the last live cell
                                    cur_next   = to_addr(len_reg - 1'b1);
                                    mem_raddr  = to_addr(len_reg - 1'b1);
                                    stop_next  = to_addr(idx);
                                    state_next = ilir_pkg::S_INS;
                                end
                            end
                        end
                        ilir_pkg::OP_GET, ilir_pkg::OP_SET:
                        begin
                            if (!tag_ok)
                            begin
                                done_res.status = ilir_pkg::ST_TYPE;
                                done            = 1'b1;
                            end
                            else if (req.position >= len_reg)
                            begin
                                done_res.status = ilir_pkg::ST_BOUNDS;
                                done            = 1'b1;
                            end
                            else if (req.op == ilir_pkg::OP_GET)
                            begin
                                mem_raddr  = to_addr(req.position);
                                state_next = ilir_pkg::S_GET;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = to_addr(req.position);
                                mem_wdata = to_elem(req.value);
                                done      = 1'b1;
                            end
                        end
                        ilir_pkg::OP_POP_BACK, ilir_pkg::OP_POP_FRONT,
                        ilir_pkg::OP_POP_AT:
                        begin
                            if (req.op == ilir_pkg::OP_POP_BACK)
                                idx = len_reg - 1'b1;
                            else if (req.op == ilir_pkg::OP_POP_FRONT)
                                idx = '0;
                            else
                                idx = req.position;

                            if (!tag_ok)
                            begin
                                done_res.status = ilir_pkg::ST_TYPE;
                                done            = 1'b1;
                            end
                            else if (len_reg == '0)
                            begin
                                done_res.status = ilir_pkg::ST_EMPTY;
                                done            = 1'b1;
                            end
                            else if (req.op == ilir_pkg::OP_POP_AT && req.position >= len_reg)
                            begin
                                done_res.status = ilir_pkg::ST_BOUNDS;
                                done            = 1'b1;
                            end
                            else
                            begin
                                // read the removed cell, then walk up shifting down
                                cur_next   = to_addr(idx);
                                mem_raddr  = to_addr(idx);
                                stop_next  = to_addr(len_reg - 1'b1);
                                first_next = 1'b1;
                                len_next   = len_reg - 1'b1;
                                state_next = ilir_pkg::S_REM;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            ilir_pkg::S_GET:
            begin
                done_res.read_value = from_elem(mem_rd_reg);
                done                = 1'b1;
            end
            ilir_pkg::S_INS:
            begin
                // data read last cycle from cur moves to cur+1
                mem_we    = 1'b1;
                mem_waddr = cur_reg + 1'b1;
                mem_wdata = mem_rd_reg;
                if (cur_reg == stop_reg)
                    state_next = ilir_pkg::S_INSV;
                else
                begin
                    cur_next  = cur_reg - 1'b1;
                    mem_raddr = cur_reg - 1'b1;
                end
            end
            ilir_pkg::S_INSV:
            begin
                mem_we    = 1'b1;
                mem_waddr = stop_reg;
                mem_wdata = val_reg;
                done      = 1'b1;
            end
            ilir_pkg::S_REM:
            begin
                first_next = 1'b0;
                if (first_reg)
                    val_next = mem_rd_reg;
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg - 1'b1;
                    mem_wdata = mem_rd_reg;
                end
                if (cur_reg == stop_reg)
                begin
                    done_res.read_value = first_reg ? from_elem(mem_rd_reg)
                                                    : from_elem(val_reg);
                    done                = 1'b1;
                end
                else
                begin
                    cur_next  = cur_reg + 1'b1;
                    mem_raddr = cur_reg + 1'b1;
                end
            end
            ilir_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_data   = res_reg;
                    state_next = ilir_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ilir_pkg::S_IDLE;
            end
        endcase

        if (done)
        begin
            done_res.length = len_next;
            if (out_free)
            begin
                out_load   = 1'b1;
                out_data   = done_res;
                state_next = ilir_pkg::S_IDLE;
            end
            else
            begin
                // output still held: park the response
                res_next   = done_res;
                state_next = ilir_pkg::S_FIN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ilir_pkg::S_IDLE;
            len_reg       <= '0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            first_reg <= first_next;
            if (out_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        stop_reg <= stop_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        if (out_load)
            rsp_reg <= out_data;
    end

endmodule
